FILE: hw/rtl/bhcf_pkg.sv
package bhcf_pkg;

  localparam int unsigned MaxTransfer = 256;
  localparam int unsigned MaxResults  = 6;
  localparam int unsigned QueueDepth  = 4;

  // input commands
  localparam logic [2:0] CMD_READ_MEM   = 3'd0;
  localparam logic [2:0] CMD_GO         = 3'd1;
  localparam logic [2:0] CMD_WRITE_MEM  = 3'd2;
  localparam logic [2:0] CMD_ERASE_SECT = 3'd3;
  localparam logic [2:0] CMD_ERASE_BANK = 3'd4;
  localparam logic [2:0] CMD_RESPONSE   = 3'd5;
  localparam logic [2:0] CMD_PAYLOAD    = 3'd6;
  localparam logic [2:0] CMD_XFER_ERROR = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_READ_REQ = 2'd1;
  localparam logic [1:0] KIND_READ_DAT = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // completion status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NACK      = 3'd1;
  localparam logic [2:0] ST_UNEXP     = 3'd2;
  localparam logic [2:0] ST_RETRIES   = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_XFER_ERR  = 3'd5;

  // opcodes
  localparam logic [7:0] OP_READ  = 8'h11;
  localparam logic [7:0] OP_GO    = 8'h21;
  localparam logic [7:0] OP_WRITE = 8'h32;
  localparam logic [7:0] OP_ERASE = 8'h45;
  localparam logic [7:0] PAD_BYTE = 8'hFF;

  // bank codes
  localparam logic [1:0] BANK_ONE     = 2'd0;
  localparam logic [1:0] BANK_TWO     = 2'd1;
  localparam logic [1:0] BANK_INVALID = 2'd3;

  // register indexes
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd0;
  localparam logic [2:0] REG_ACK_CODE    = 3'd1;
  localparam logic [2:0] REG_NACK_CODE   = 3'd2;
  localparam logic [2:0] REG_BUSY_CODE   = 3'd3;
  localparam logic [2:0] REG_ERASE_HIGH  = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [8:0]  length;
    logic [16:0] sector_count;
    logic [1:0]  bank;
    logic [15:0] payload;
    logic        payload_last;
    logic [7:0]  response;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [8:0] read_count;
    logic       frame_end;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [7:0] busy_code;
    logic [7:0] erase_high;
  } cfg_t;

  // group of results caused by one input item
  typedef struct packed {
    logic [2:0]               cnt;
    out_item_t [MaxResults-1:0] res;
  } burst_t;

  function automatic out_item_t mk_tx(logic [7:0] b, logic fe);
    out_item_t r;
    r = '0;
    r.out_kind  = KIND_TX;
    r.out_byte  = b;
    r.frame_end = fe;
    return r;
  endfunction

  function automatic out_item_t mk_done(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_DONE;
    r.status   = st;
    return r;
  endfunction

endpackage

FILE: hw/rtl/bhcf_front.sv
module bhcf_front import bhcf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output burst_t   burst_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT_CMD, PH_WAIT_ADDR, PH_WAIT_CNT, PH_COLLECT, PH_WAIT_FINAL, PH_READING
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [8:0]  len_q, len_d;
  logic [16:0] rem_q, rem_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  att_q, att_d;
  logic [31:0] addr_q, addr_d;

  burst_t      b;
  logic [2:0]  n;
  logic        bad;
  logic [7:0]  op, lo, x, c8, hi8, chk_new;
  logic [15:0] c16;
  logic [16:0] rem_dec;

  // classify the item and build its results
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    rem_d   = rem_q;
    chk_d   = chk_q;
    att_d   = att_q;
    addr_d  = addr_q;
    b       = '0;
    n       = '0;
    bad     = 1'b0;
    op      = OP_ERASE;
    lo      = PAD_BYTE;
    x       = addr_q[31:24] ^ addr_q[23:16] ^ addr_q[15:8] ^ addr_q[7:0];
    c16     = 16'(rem_q - 17'd1);
    c8      = '0;
    hi8     = '0;
    chk_new = chk_q;
    rem_dec = rem_q - 17'd1;
    if (valid_i) begin
      if (item_i.command <= CMD_ERASE_BANK) begin
        if (phase_q == PH_IDLE) begin
          case (item_i.command)
            CMD_READ_MEM, CMD_WRITE_MEM:
              bad = (item_i.length == '0) || (32'(item_i.length) > MaxTransfer);
            CMD_ERASE_SECT:
              bad = (item_i.sector_count == '0) || item_i.sector_count[16] &&
                    (item_i.sector_count[15:0] != '0);
            CMD_ERASE_BANK: bad = (item_i.bank == BANK_INVALID);
            default:        bad = 1'b0;
          endcase
          case (item_i.command)
            CMD_READ_MEM:  op = OP_READ;
            CMD_GO:        op = OP_GO;
            CMD_WRITE_MEM: op = OP_WRITE;
            default:       op = OP_ERASE;
          endcase
          att_d = '0;
          if (bad) begin
            b.res[0] = mk_done(ST_INVALID);
            n = 3'd1;
          end else begin
            cmd_d  = item_i.command;
            len_d  = item_i.length;
            addr_d = (item_i.command == CMD_ERASE_BANK) ? {30'd0, item_i.bank} :
                     item_i.address;
            rem_d  = (item_i.command == CMD_ERASE_SECT) ? item_i.sector_count : '0;
            chk_d  = '0;
            b.res[0] = mk_tx(op, 1'b0);
            b.res[1] = mk_tx(op ^ PAD_BYTE, 1'b1);
            n = 3'd2;
            phase_d = PH_WAIT_CMD;
          end
        end
      end else if (item_i.command == CMD_XFER_ERROR) begin
        if (phase_q != PH_IDLE) begin
          b.res[0] = mk_done(ST_XFER_ERR);
          n = 3'd1;
          phase_d = PH_IDLE;
          att_d = '0;
        end
      end else if (item_i.command == CMD_RESPONSE) begin
        if (phase_q == PH_READING) begin
          b.res[0] = '0;
          b.res[0].out_kind = KIND_READ_DAT;
          b.res[0].out_byte = item_i.response;
          n = 3'd1;
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            b.res[1] = mk_done(ST_OK);
            n = 3'd2;
            phase_d = PH_IDLE;
            att_d = '0;
          end
        end else if (phase_q != PH_IDLE && phase_q != PH_COLLECT) begin
          if (item_i.response == cfg_i.busy_code) begin
            if (att_q >= cfg_i.retry_limit) begin
              b.res[0] = mk_done(ST_RETRIES);
              n = 3'd1;
              phase_d = PH_IDLE;
              att_d = '0;
            end else begin
              att_d = att_q + 8'd1;
            end
          end else if (item_i.response == cfg_i.ack_code) begin
            case (phase_q)
              PH_WAIT_CMD: begin
                att_d = '0;
                if (cmd_q <= CMD_WRITE_MEM) begin
                  b.res[0] = mk_tx(addr_q[31:24], 1'b0);
                  b.res[1] = mk_tx(addr_q[23:16], 1'b0);
                  b.res[2] = mk_tx(addr_q[15:8], 1'b0);
                  b.res[3] = mk_tx(addr_q[7:0], 1'b0);
                  b.res[4] = mk_tx(x, 1'b1);
                  n = 3'd5;
                  phase_d = PH_WAIT_ADDR;
                end else if (cmd_q == CMD_ERASE_SECT) begin
                  b.res[0] = mk_tx(c16[15:8], 1'b0);
                  b.res[1] = mk_tx(c16[7:0], 1'b0);
                  b.res[2] = mk_tx(c16[15:8] ^ c16[7:0], 1'b1);
                  n = 3'd3;
                  phase_d = PH_WAIT_CNT;
                end else begin
                  case (addr_q[1:0])
                    BANK_ONE: lo = 8'hFE;
                    BANK_TWO: lo = 8'hFD;
                    default:  lo = PAD_BYTE;
                  endcase
                  if (addr_q[31:2] != '0) lo = PAD_BYTE;
                  b.res[0] = mk_tx(cfg_i.erase_high, 1'b0);
                  b.res[1] = mk_tx(lo, 1'b0);
                  b.res[2] = mk_tx(cfg_i.erase_high ^ lo, 1'b1);
                  n = 3'd3;
                  phase_d = PH_WAIT_FINAL;
                end
              end
              PH_WAIT_ADDR: begin
                if (cmd_q == CMD_READ_MEM) begin
                  c8 = 8'(len_q - 9'd1);
                  b.res[0] = mk_tx(c8, 1'b0);
                  b.res[1] = mk_tx(c8 ^ PAD_BYTE, 1'b1);
                  n = 3'd2;
                  phase_d = PH_WAIT_CNT;
                  att_d = '0;
                end else if (cmd_q == CMD_GO) begin
                  b.res[0] = mk_done(ST_OK);
                  n = 3'd1;
                  phase_d = PH_IDLE;
                  att_d = '0;
                end else begin
                  c8 = len_q[0] ? len_q[7:0] : 8'(len_q - 9'd1);
                  b.res[0] = mk_tx(c8, 1'b0);
                  n = 3'd1;
                  chk_d = c8;
                  rem_d = {8'd0, len_q};
                  phase_d = PH_COLLECT;
                end
              end
              PH_WAIT_CNT: begin
                if (cmd_q == CMD_READ_MEM) begin
                  b.res[0] = '0;
                  b.res[0].out_kind   = KIND_READ_REQ;
                  b.res[0].read_count = len_q;
                  n = 3'd1;
                  rem_d = {8'd0, len_q};
                  phase_d = PH_READING;
                end else begin
                  chk_d = '0;
                  phase_d = PH_COLLECT;
                end
              end
              default: begin
                b.res[0] = mk_done(ST_OK);
                n = 3'd1;
                phase_d = PH_IDLE;
                att_d = '0;
              end
            endcase
          end else begin
            b.res[0] = mk_done((item_i.response == cfg_i.nack_code) ? ST_NACK : ST_UNEXP);
            n = 3'd1;
            phase_d = PH_IDLE;
            att_d = '0;
          end
        end
      end else if (phase_q == PH_COLLECT) begin
        // payload item: data byte or sector number
        if (cmd_q == CMD_WRITE_MEM) begin
          b.res[0] = mk_tx(item_i.payload[7:0], 1'b0);
          n = 3'd1;
          chk_new = chk_q ^ item_i.payload[7:0];
        end else begin
          hi8 = item_i.payload[15:8];
          b.res[0] = mk_tx(hi8, 1'b0);
          b.res[1] = mk_tx(item_i.payload[7:0], 1'b0);
          n = 3'd2;
          chk_new = chk_q ^ hi8 ^ item_i.payload[7:0];
        end
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          if (cmd_q == CMD_WRITE_MEM && len_q[0]) begin
            b.res[n] = mk_tx(PAD_BYTE, 1'b0);
            n = n + 3'd1;
            chk_new = chk_new ^ PAD_BYTE;
          end
          b.res[n] = mk_tx(chk_new, 1'b1);
          n = n + 3'd1;
          phase_d = PH_WAIT_FINAL;
          att_d = '0;
        end
        chk_d = chk_new;
      end
    end
    b.cnt = n;
  end

  assign burst_o = b;

  // command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      chk_q   <= '0;
      att_q   <= '0;
      addr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      chk_q   <= chk_d;
      att_q   <= att_d;
      addr_q  <= addr_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_resp_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && phase_q == PH_IDLE && item_i.command == CMD_RESPONSE) |-> (b.cnt == '0))
    else $error("response while idle produced results");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b.cnt <= 3'(MaxResults))
    else $error("too many results for one item");
  a_att_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (att_q == '0))
    else $error("attempt count left over while idle");
`endif

endmodule

FILE: hw/rtl/bhcf_queue.sv
module bhcf_queue import bhcf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  burst_t wdata_i,
  output logic   full_o,
  input  logic   rd_i,
  output logic   empty_o,
  output burst_t rdata_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  burst_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // burst storage
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr_i && !full_o) - (PtrW+1)'(rd_i && !empty_o);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth))
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wp_q - rp_q) == PtrW'(cnt_q))
    else $error("queue pointers disagree with count");
  a_no_empty_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (rdata_o.cnt != '0))
    else $error("empty burst stored");
`endif

endmodule

FILE: hw/rtl/bhcf_back.sv
module bhcf_back import bhcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  burst_t    q_data_i,
  output logic      q_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_o
);

  burst_t     cur_q;
  logic [2:0] idx_q;
  logic       valid_q;
  logic       last;
  logic       take;

  assign last    = (idx_q == cur_q.cnt - 3'd1);
  assign take    = (!valid_q || (pop_i && last)) && !q_empty_i;
  assign q_rd_o  = take;
  assign empty_o = !valid_q;
  assign out_o   = cur_q.res[idx_q];

  // hand out the current burst one result per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      cur_q   <= '0;
    end else if (take) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
      cur_q   <= q_data_i;
    end else if (valid_q && pop_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < cur_q.cnt))
    else $error("result index past burst end");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && pop_i && last && q_empty_i) |=> !valid_q)
    else $error("result stage not drained");
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q && !q_empty_i) |=> (valid_q && idx_q == '0))
    else $error("waiting burst not loaded");
`endif

endmodule

FILE: hw/rtl/bootloader_host_command_framer.sv
// channel   direction  transfer when       payload
// input     in         push && !full       in_i   (in_item_t)
// result    out        pop && !empty       out_o  (out_item_t)
// config    in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// an input item is classified in the cycle it is taken; its results (up to five) go
// into a four-entry burst queue, handed out one per cycle while pop is high.
// items are taken every cycle while the burst queue has room; full rises only when
// four bursts wait, so the result side sets the sustained rate in long bursts.
// reset clears the command state and loads the register defaults; no clearing pass.
module bootloader_host_command_framer import bhcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t   cfg_q;
  burst_t burst;
  burst_t q_data;
  logic   q_empty;
  logic   q_rd;
  logic   accept;

  assign accept = push && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit <= 8'd60;
      cfg_q.ack_code    <= 8'h79;
      cfg_q.nack_code   <= 8'h1F;
      cfg_q.busy_code   <= 8'h76;
      cfg_q.erase_high  <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data_i;
        REG_ACK_CODE:    cfg_q.ack_code    <= cfg_data_i;
        REG_NACK_CODE:   cfg_q.nack_code   <= cfg_data_i;
        REG_BUSY_CODE:   cfg_q.busy_code   <= cfg_data_i;
        REG_ERASE_HIGH:  cfg_q.erase_high  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bhcf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (in_i),
    .cfg_i   (cfg_q),
    .burst_o (burst)
  );

  bhcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept && (burst.cnt != '0)),
    .wdata_i (burst),
    .full_o  (full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  bhcf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_o     (out_o)
  );

endmodule
